@@ rtl/cpr_pkg.sv @@
`timescale 1ns / 1ps

package cpr_pkg;

    localparam int COORD_BITS    = 12;
    localparam int HIST_DEPTH    = 64;
    localparam int HIST_AW       = $clog2(HIST_DEPTH);
    localparam int CNT_BITS      = 6;
    localparam int LIMIT_CAP     = 62;
    localparam int TOL_BITS      = 16;
    localparam int FRAC_BITS     = 8;

    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int PROD_BITS     = 2 * COORD_BITS + 1;
    localparam int MUL_A_BITS    = PROD_BITS;
    localparam int MUL_B_BITS    = TOL_BITS + 1;
    localparam int MUL_P_BITS    = MUL_A_BITS + MUL_B_BITS;
    localparam int CMP_BITS      = 2 * COORD_BITS + TOL_BITS + 1;
    localparam int WIDX_BITS     = (CNT_BITS + 1 > HIST_AW) ? CNT_BITS + 1 : HIST_AW;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOPE_TOL = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TEST_LIM  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AVG_MODE  = 2'd2;

    localparam logic [TOL_BITS-1:0] TOL_RESET   = 16'd3;
    localparam logic [CNT_BITS-1:0] LIMIT_RESET = 6'd8;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
    } t_point;

    typedef struct packed {
        t_point pt;
        logic   last_pt;
    } t_result;

    typedef struct packed {
        logic                         en;
        logic signed [MUL_A_BITS-1:0] a;
        logic signed [MUL_B_BITS-1:0] b;
    } t_mul_req;

    typedef enum logic [1:0] {
        PH_EMPTY  = 2'd0,
        PH_ANCHOR = 2'd1,
        PH_RUN    = 2'd2
    } t_phase;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_DECIDE,
        S_EMIT_A,
        S_EMIT_B
    } t_state;

endpackage

@@ rtl/cpr_ram.sv @@
`timescale 1ns / 1ps

module cpr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/cpr_mul.sv @@
`timescale 1ns / 1ps

module cpr_mul
    import cpr_pkg::*;
(
    input  logic                         i_clk,
    input  t_mul_req                     i_req,
    output logic signed [MUL_P_BITS-1:0] o_prod
);

    logic signed [MUL_P_BITS-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= $signed(i_req.a) * $signed(i_req.b);
        end
    end

    assign o_prod = r_prod;

endmodule

@@ rtl/collinear_point_reducer.sv @@
`timescale 1ns / 1ps

// Collinear point reducer: takes the points of a 2D outline one transaction at a
// time on the input channel (i_in_valid / o_in_ready) and passes on only the points
// where the outline turns, on the output channel (o_out_valid / i_out_ready).
// The first and last point of each outline always come out; a point flagged
// i_final_point closes the outline. One input may give zero, one or two results;
// o_last_of_run marks the last result of an input.
// The first point of an outline and a lone final point go straight to the emit
// state; the second point of an outline is absorbed while o_in_ready stays high.
// Any later point runs a slope test of four passes through one shared
// multiplier, between a setup state and a decide state; the block is ready
// again once its results, if any, have gone to the output register, as
// o_in_ready is high only while the sequencer is idle.
// A result waits in the output register while the receiver stalls; a new point may
// be accepted meanwhile, and its own results wait until the register is free.
// Reset (synchronous, active low) empties the outline state and the output register
// and loads the register defaults: tolerance 3 (Q8.8), test limit 8, average off.
// The run history needs no clearing: only entries written in the current run are read.
// Configuration writes must be made while no transaction is in flight.

module collinear_point_reducer
    import cpr_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [COORD_BITS-1:0]    i_point_x,
    input  logic [COORD_BITS-1:0]    i_point_y,
    input  logic                     i_final_point,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [COORD_BITS-1:0]    o_out_x,
    output logic [COORD_BITS-1:0]    o_out_y,
    output logic                     o_outline_end,
    output logic                     o_last_of_run,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_state                       r_state, n_state;
    t_phase                       r_phase, n_phase;
    t_point                       r_anchor, n_anchor;
    t_point                       r_prev, n_prev;
    logic [CNT_BITS-1:0]          r_run_count, n_run_count;
    logic [TOL_BITS-1:0]          r_tol;
    logic [CNT_BITS-1:0]          r_limit;
    logic                         r_avg;
    t_point                       r_pt, n_pt;
    logic                         r_fin, n_fin;
    logic signed [DIFF_BITS-1:0]  r_dx2, r_dy2, r_dx3, r_dy3;
    logic signed [DIFF_BITS-1:0]  n_dx2, n_dy2, n_dx3, n_dy3;
    logic                         r_eqy, r_eqx, r_zdx, n_eqy, n_eqx, n_zdx;
    logic signed [PROD_BITS-1:0]  r_p1, n_p1;
    logic [PROD_BITS-1:0]         r_cross, n_cross;
    t_result                      r_pend_a, n_pend_a, r_pend_b, n_pend_b;
    logic                         r_two, n_two;
    logic                         r_out_valid, n_out_valid;
    t_result                      r_out, n_out;
    logic                         r_out_last, n_out_last;

    t_mul_req                     mul_req;
    logic signed [MUL_P_BITS-1:0] mul_prod;

    logic                         ram_we, ram_re;
    logic [HIST_AW-1:0]           ram_waddr, ram_raddr;
    t_point                       ram_wdata, ram_rdata;

    logic                         in_fire, out_free;
    logic [CNT_BITS-1:0]          count, limit;
    logic [WIDX_BITS-1:0]         half_idx, next_idx;
    t_point                       mid;
    logic signed [PROD_BITS:0]    diff;
    logic signed [PROD_BITS-1:0]  p_low;
    logic [PROD_BITS-1:0]         abs3;
    logic [CMP_BITS-1:0]          lhs, rhs;
    logic                         same, brk;

    cpr_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (mul_prod)
    );

    cpr_ram #(
        .WIDTH ($bits(t_point)),
        .DEPTH (HIST_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready    = (r_state == S_IDLE);
    assign in_fire       = i_in_valid && o_in_ready;
    assign out_free      = !r_out_valid || i_out_ready;
    assign o_out_valid   = r_out_valid;
    assign o_out_x       = r_out.pt.x;
    assign o_out_y       = r_out.pt.y;
    assign o_outline_end = r_out.last_pt;
    assign o_last_of_run = r_out_last;

    // run length of the current test and its history indexes
    assign count    = r_run_count + CNT_BITS'(1);
    assign limit    = (r_limit > CNT_BITS'(LIMIT_CAP)) ? CNT_BITS'(LIMIT_CAP) : r_limit;
    assign half_idx = WIDX_BITS'(count >> 1);
    assign next_idx = WIDX_BITS'(count) + WIDX_BITS'(1);

    assign ram_re    = (r_state == S_IDLE);
    assign ram_raddr = (half_idx > WIDX_BITS'(HIST_DEPTH - 1)) ?
                       HIST_AW'(HIST_DEPTH - 1) : half_idx[HIST_AW-1:0];

    assign mid   = (r_avg && (r_run_count != '0)) ? ram_rdata : r_prev;
    assign p_low = mul_prod[PROD_BITS-1:0];
    assign diff  = $signed({r_p1[PROD_BITS-1], r_p1}) - $signed({p_low[PROD_BITS-1], p_low});
    assign abs3  = p_low[PROD_BITS-1] ? PROD_BITS'(-p_low) : PROD_BITS'(p_low);
    assign lhs   = CMP_BITS'({r_cross, {FRAC_BITS{1'b0}}});
    assign rhs   = mul_prod[CMP_BITS-1:0];
    assign same  = r_eqy || r_eqx || (!r_zdx && (lhs <= rhs));
    assign brk   = !same || (count > limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_EMPTY;
            r_run_count <= '0;
            r_anchor    <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
            r_limit     <= LIMIT_RESET;
            r_avg       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_run_count <= n_run_count;
            r_anchor    <= n_anchor;
            r_prev      <= n_prev;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SLOPE_TOL: r_tol   <= i_cfg_data[TOL_BITS-1:0];
                    CFG_TEST_LIM:  r_limit <= i_cfg_data[CNT_BITS-1:0];
                    CFG_AVG_MODE:  r_avg   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
        r_pt       <= n_pt;
        r_fin      <= n_fin;
        r_dx2      <= n_dx2;
        r_dy2      <= n_dy2;
        r_dx3      <= n_dx3;
        r_dy3      <= n_dy3;
        r_eqy      <= n_eqy;
        r_eqx      <= n_eqx;
        r_zdx      <= n_zdx;
        r_p1       <= n_p1;
        r_cross    <= n_cross;
        r_pend_a   <= n_pend_a;
        r_pend_b   <= n_pend_b;
        r_two      <= n_two;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_anchor    = r_anchor;
        n_prev      = r_prev;
        n_run_count = r_run_count;
        n_pt        = r_pt;
        n_fin       = r_fin;
        n_dx2       = r_dx2;
        n_dy2       = r_dy2;
        n_dx3       = r_dx3;
        n_dy3       = r_dy3;
        n_eqy       = r_eqy;
        n_eqx       = r_eqx;
        n_zdx       = r_zdx;
        n_p1        = r_p1;
        n_cross     = r_cross;
        n_pend_a    = r_pend_a;
        n_pend_b    = r_pend_b;
        n_two       = r_two;
        n_out       = r_out;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_out_ready;
        mul_req     = '0;
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_pt;

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_pt.x = i_point_x;
                    n_pt.y = i_point_y;
                    n_fin  = i_final_point;
                    case (r_phase)
                        PH_ANCHOR: begin
                            if (i_final_point) begin
                                n_pend_a = '{pt: n_pt, last_pt: 1'b1};
                                n_two    = 1'b0;
                                n_phase  = PH_EMPTY;
                                n_state  = S_EMIT_A;
                            end else begin
                                n_prev      = n_pt;
                                n_run_count = '0;
                                n_phase     = PH_RUN;
                                ram_we      = 1'b1;
                                ram_waddr   = HIST_AW'(1);
                                ram_wdata   = n_pt;
                            end
                        end
                        PH_RUN: begin
                            n_state = S_SETUP;
                        end
                        default: begin
                            n_pend_a = '{pt: n_pt, last_pt: i_final_point};
                            n_two    = 1'b0;
                            n_state  = S_EMIT_A;
                            if (i_final_point) begin
                                n_phase = PH_EMPTY;
                            end else begin
                                n_anchor    = n_pt;
                                n_run_count = '0;
                                n_phase     = PH_ANCHOR;
                            end
                        end
                    endcase
                end
            end
            S_SETUP: begin
                n_dx2   = $signed({1'b0, mid.x} - {1'b0, r_anchor.x});
                n_dy2   = $signed({1'b0, mid.y} - {1'b0, r_anchor.y});
                n_dx3   = $signed({1'b0, r_pt.x} - {1'b0, r_anchor.x});
                n_dy3   = $signed({1'b0, r_pt.y} - {1'b0, r_anchor.y});
                n_eqy   = (r_anchor.y == mid.y) && (mid.y == r_pt.y);
                n_eqx   = (r_anchor.x == mid.x) && (mid.x == r_pt.x);
                n_zdx   = (mid.x == r_anchor.x) || (r_pt.x == r_anchor.x);
                n_state = S_MUL1;
            end
            S_MUL1: begin
                mul_req = '{en: 1'b1, a: MUL_A_BITS'(r_dy2), b: MUL_B_BITS'(r_dx3)};
                n_state = S_MUL2;
            end
            S_MUL2: begin
                mul_req = '{en: 1'b1, a: MUL_A_BITS'(r_dy3), b: MUL_B_BITS'(r_dx2)};
                n_p1    = p_low;
                n_state = S_MUL3;
            end
            S_MUL3: begin
                mul_req = '{en: 1'b1, a: MUL_A_BITS'(r_dx2), b: MUL_B_BITS'(r_dx3)};
                n_cross = diff[PROD_BITS] ? PROD_BITS'(-diff) : PROD_BITS'(diff);
                n_state = S_MUL4;
            end
            S_MUL4: begin
                mul_req = '{en: 1'b1, a: $signed(abs3), b: $signed({1'b0, r_tol})};
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                n_prev = r_pt;
                ram_we = 1'b1;
                if (brk) begin
                    n_anchor    = r_prev;
                    n_run_count = '0;
                    ram_waddr   = HIST_AW'(1);
                    n_pend_a    = '{pt: r_prev, last_pt: 1'b0};
                    n_pend_b    = '{pt: r_pt, last_pt: 1'b1};
                    n_two       = r_fin;
                end else begin
                    n_run_count = count;
                    ram_we      = (next_idx < WIDX_BITS'(HIST_DEPTH));
                    ram_waddr   = next_idx[HIST_AW-1:0];
                    n_pend_a    = '{pt: r_pt, last_pt: 1'b1};
                    n_two       = 1'b0;
                end
                if (r_fin) begin
                    n_phase = PH_EMPTY;
                end
                n_state = (brk || r_fin) ? S_EMIT_A : S_IDLE;
            end
            S_EMIT_A: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend_a;
                    n_out_last  = !r_two;
                    n_state     = r_two ? S_EMIT_B : S_IDLE;
                end
            end
            S_EMIT_B: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_pend_b;
                    n_out_last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cpr_checker.sv @@
`timescale 1ns / 1ps

module cpr_checker
    import cpr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_final_point,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [COORD_BITS-1:0] o_out_x,
    input logic [COORD_BITS-1:0] o_out_y,
    input logic                  o_outline_end,
    input logic                  o_last_of_run
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_x) && $stable(o_out_y)
            && $stable(o_outline_end) && $stable(o_last_of_run))
        else $error("result changed while stalled");

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_outline_end |-> o_last_of_run)
        else $error("outline end not last of run");

    // second result follows straight on
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=> o_out_valid)
        else $error("second result missing");

    // a final point always yields a result, so the sequencer is busy next cycle
    a_final_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_final_point |=> !o_in_ready)
        else $error("final point left no work");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result present after reset");

endmodule

bind collinear_point_reducer cpr_checker u_cpr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_final_point (i_final_point),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_out_x       (o_out_x),
    .o_out_y       (o_out_y),
    .o_outline_end (o_outline_end),
    .o_last_of_run (o_last_of_run)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import cpr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_POINTS   = 120;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  fin;
    } t_in_pt;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  outline_end;
        logic                  last_of_run;
    } t_kept;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [COORD_BITS-1:0]    i_point_x = '0;
    logic [COORD_BITS-1:0]    i_point_y = '0;
    logic                     i_final_point = 1'b0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [COORD_BITS-1:0]    o_out_x;
    logic [COORD_BITS-1:0]    o_out_y;
    logic                     o_outline_end;
    logic                     o_last_of_run;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    collinear_point_reducer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_final_point (i_final_point),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_x       (o_out_x),
        .o_out_y       (o_out_y),
        .o_outline_end (o_outline_end),
        .o_last_of_run (o_last_of_run),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // reducer state as the testbench sees it
    logic [TOL_BITS-1:0] tol_q88 = TOL_RESET;
    logic [CNT_BITS-1:0] max_tests = LIMIT_RESET;
    logic                avg_mid = 1'b0;
    t_point              anchor;
    t_point              prev_pt;
    logic [CNT_BITS-1:0] tests_run = '0;
    t_phase              phase = PH_EMPTY;
    t_point              history [HIST_DEPTH];

    t_in_pt pending_pts [$];
    t_kept  kept_points [$];
    t_in_pt cur_pt;

    int points_queued   = 0;
    int points_accepted = 0;
    int outlines        = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int burst_left      = 0;
    int gap_left        = 0;
    int stall_tick      = 0;
    int quiet_cycles    = 0;

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= 40)
            $display("MISMATCH @%0t result %0d: %s", $time, results_checked, what);
    endtask

    function automatic bit on_one_line(t_point a, t_point m, t_point p);
        longint dx2, dy2, dx3, dy3, cross_mag, span;
        if (a.y == m.y && m.y == p.y)
            return 1'b1;
        if (a.x == m.x && m.x == p.x)
            return 1'b1;
        dx2 = longint'(m.x) - longint'(a.x);
        dx3 = longint'(p.x) - longint'(a.x);
        if (dx2 == 0 || dx3 == 0)
            return 1'b0;
        dy2 = longint'(m.y) - longint'(a.y);
        dy3 = longint'(p.y) - longint'(a.y);
        cross_mag = dy2 * dx3 - dy3 * dx2;
        if (cross_mag < 0)
            cross_mag = -cross_mag;
        span = dx2 * dx3;
        if (span < 0)
            span = -span;
        return cross_mag * 256 <= longint'(tol_q88) * span;
    endfunction

    function automatic void reduce_point(t_in_pt ip);
        t_point      p, mid;
        t_kept       res [2];
        int unsigned cnt, lim, mid_idx;
        int          n;
        p.x = ip.x;
        p.y = ip.y;
        n = 0;
        case (phase)
            PH_ANCHOR: begin
                if (ip.fin) begin
                    res[n] = '{x: p.x, y: p.y, outline_end: 1'b1, last_of_run: 1'b0};
                    n++;
                    phase = PH_EMPTY;
                end else begin
                    prev_pt = p;
                    history[1] = p;
                    tests_run = '0;
                    phase = PH_RUN;
                end
            end
            PH_RUN: begin
                cnt = tests_run + 1;
                lim = (max_tests > LIMIT_CAP) ? LIMIT_CAP : max_tests;
                mid = prev_pt;
                if (avg_mid && cnt > 1) begin
                    mid_idx = (cnt / 2 >= HIST_DEPTH) ? HIST_DEPTH - 1 : cnt / 2;
                    mid = history[mid_idx];
                end
                if (!on_one_line(anchor, mid, p) || cnt > lim) begin
                    res[n] = '{x: prev_pt.x, y: prev_pt.y, outline_end: 1'b0,
                               last_of_run: 1'b0};
                    n++;
                    anchor = prev_pt;
                    history[0] = prev_pt;
                    tests_run = '0;
                    history[1] = p;
                end else begin
                    tests_run = CNT_BITS'(cnt);
                    if (cnt + 1 < HIST_DEPTH)
                        history[cnt + 1] = p;
                end
                prev_pt = p;
                if (ip.fin) begin
                    res[n] = '{x: p.x, y: p.y, outline_end: 1'b1, last_of_run: 1'b0};
                    n++;
                    phase = PH_EMPTY;
                end
            end
            default: begin
                res[n] = '{x: p.x, y: p.y, outline_end: ip.fin, last_of_run: 1'b0};
                n++;
                if (ip.fin) begin
                    phase = PH_EMPTY;
                end else begin
                    anchor = p;
                    history[0] = p;
                    tests_run = '0;
                    phase = PH_ANCHOR;
                end
            end
        endcase
        for (int k = 0; k < n; k++) begin
            res[k].last_of_run = (k == n - 1);
            kept_points = {kept_points, res[k]};
        end
    endfunction

    // sender: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin : driver
        logic next_valid;
        next_valid = i_in_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                reduce_point(cur_pt);
                points_accepted++;
                next_valid = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 3);
                        2: gap_left = $urandom_range(4, 15);
                        default: gap_left = $urandom_range(20, 40);
                    endcase
                end
            end
            if (!next_valid && pending_pts.size() > 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    cur_pt = pending_pts.pop_front();
                    next_valid = 1'b1;
                    i_point_x <= cur_pt.x;
                    i_point_y <= cur_pt.y;
                    i_final_point <= cur_pt.fin;
                end
            end
        end
        i_in_valid <= next_valid;
    end

    // receiver: checks kept points and stalls on a rotating pattern
    always @(posedge i_clk) begin : monitor
        t_kept want;
        logic  ready_next;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (kept_points.size() == 0) begin
                report_mismatch($sformatf("unexpected point (%0d,%0d)", o_out_x, o_out_y));
            end else begin
                want = kept_points.pop_front();
                if (o_out_x !== want.x)
                    report_mismatch($sformatf("out_x %0d, expected %0d", o_out_x, want.x));
                if (o_out_y !== want.y)
                    report_mismatch($sformatf("out_y %0d, expected %0d", o_out_y, want.y));
                if (o_outline_end !== want.outline_end)
                    report_mismatch($sformatf("outline_end %b, expected %b",
                                              o_outline_end, want.outline_end));
                if (o_last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("last_of_run %b, expected %b",
                                              o_last_of_run, want.last_of_run));
                results_checked++;
            end
        end
        stall_tick++;
        case ((stall_tick / 128) % 4)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = (stall_tick % 7) >= 3;
            default: ready_next = (stall_tick % 40) >= 30;
        endcase
        i_out_ready <= ready_next;
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    task automatic push_pt(int x, int y, bit fin);
        t_in_pt ip;
        ip.x = x[COORD_BITS-1:0];
        ip.y = y[COORD_BITS-1:0];
        ip.fin = fin;
        pending_pts = {pending_pts, ip};
        points_queued++;
        if (fin)
            outlines++;
    endtask

    // polyline of straight segments with occasional jitter, or pure noise
    task automatic queue_outline(int n_pts);
        int x, y, dx, dy, seg;
        bit noisy;
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
        dx = 0;
        dy = 0;
        seg = 0;
        noisy = ($urandom_range(0, 7) == 0);
        for (int i = 0; i < n_pts; i++) begin
            if (noisy) begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end else begin
                if (seg == 0) begin
                    seg = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 10);
                    case ($urandom_range(0, 3))
                        0: begin
                            dx = $urandom_range(0, 40) - 20;
                            dy = 0;
                        end
                        1: begin
                            dx = 0;
                            dy = $urandom_range(0, 40) - 20;
                        end
                        default: begin
                            dx = $urandom_range(0, 16) - 8;
                            dy = $urandom_range(0, 16) - 8;
                        end
                    endcase
                end
                seg--;
                x += dx;
                y += dy;
                if ($urandom_range(0, 9) == 0)
                    x += $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 9) == 0)
                    y += $urandom_range(0, 2) - 1;
                if (x < 0) x = 0;
                if (x > 4095) x = 4095;
                if (y < 0) y = 0;
                if (y > 4095) y = 4095;
            end
            push_pt(x, y, i == n_pts - 1);
        end
    endtask

    task automatic wait_idle();
        while (points_accepted != points_queued || kept_points.size() > 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        case (idx)
            CFG_SLOPE_TOL: tol_q88 = value;
            CFG_TEST_LIM:  max_tests = value[CNT_BITS-1:0];
            CFG_AVG_MODE:  avg_mid = value[0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int tol, int lim, bit avg);
        write_reg(CFG_SLOPE_TOL, tol[CFG_DATA_BITS-1:0]);
        write_reg(CFG_TEST_LIM, lim[CFG_DATA_BITS-1:0]);
        write_reg(CFG_AVG_MODE, {{(CFG_DATA_BITS-1){1'b0}}, avg});
    endtask

    initial begin : stimulus
        int goal;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: lone point, two points, flat and upright lines,
        // zero dx against the middle and against the new point, straight diagonal
        push_pt(4095, 4095, 1);
        push_pt(0, 4095, 0);
        push_pt(4095, 0, 1);
        push_pt(0, 10, 0);
        push_pt(5, 10, 0);
        push_pt(10, 10, 0);
        push_pt(4095, 10, 1);
        push_pt(7, 0, 0);
        push_pt(7, 100, 0);
        push_pt(7, 4095, 1);
        push_pt(50, 50, 0);
        push_pt(50, 60, 0);
        push_pt(70, 80, 1);
        push_pt(100, 100, 0);
        push_pt(200, 200, 0);
        push_pt(100, 300, 0);
        push_pt(100, 400, 1);
        for (int i = 0; i < 7; i++)
            push_pt(10 + 2 * i, 20 + 4 * i, i == 6);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: configure(0, 0, 1'b1);
                1: configure(65535, 63, 1'b0);
                2: configure(256, 62, 1'b1);
                3: configure(3, 8, 1'b0);
                default: configure(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                               : $urandom_range(0, 64),
                                   $urandom_range(0, 63), 1'($urandom_range(0, 1)));
            endcase
            goal = points_queued + PHASE_POINTS;
            while (points_queued < goal)
                queue_outline(($urandom_range(0, 9) == 0) ? $urandom_range(60, 100)
                                                          : $urandom_range(1, 24));
            wait_idle();
        end

        $display("%0d points in %0d outlines over %0d register settings",
                 points_accepted, outlines, RANDOM_PHASES + 1);
        $display("%0d kept points checked, %0d mismatches", results_checked, mismatches);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cpr_pkg.sv
rtl/cpr_ram.sv
rtl/cpr_mul.sv
rtl/collinear_point_reducer.sv
rtl/cpr_checker.sv
test/testbench.sv
